// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of the band mask block.
// Depends on nothing; the including module supplies clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define TBM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("band mask assertion failed");

// Check that a condition never holds outside reset.
`define TBM_ASSERT_NEVER(lbl, expr) \
  `TBM_ASSERT(lbl, !(expr))

`endif

// ===== hw/rtl/tbm_pkg.sv =====
// Package of the terrain band mask block: widths, latencies, shared types.
// Holds the CORDIC arctangent table. Depends on nothing.
package tbm_pkg;

  localparam int HEIGHT_WIDTH = 24;
  localparam int SPW          = 24;
  localparam int DW           = HEIGHT_WIDTH;
  localparam int PW           = DW + SPW;
  localparam int GW           = 31;
  localparam int NW           = 2 * GW + 1;
  localparam int SQRT_STEPS   = 32;
  localparam int RW           = 64;
  localparam int ROOTW        = 32;
  localparam int CORDIC_STEPS = 20;
  localparam int CW           = 56;
  localparam int ZW           = 26;
  localparam int SLW          = 15;
  localparam int XW           = ((HEIGHT_WIDTH + 1) > 25 ? (HEIGHT_WIDTH + 1) : 25) + 1;
  localparam int BW           = 24;
  localparam int FW           = 23;
  localparam int DIV_STEPS    = 15;
  localparam int WW           = 16;
  localparam int ADDR_W       = 5;

  localparam logic [WW-1:0] ONE_Q15 = 16'h8000;

  localparam int GRAD_LAT    = 5 + SQRT_STEPS;
  localparam int CORDIC_LAT  = CORDIC_STEPS + 1;
  localparam int BAND_LAT    = 1 + DIV_STEPS + 4;
  localparam int TBM_LATENCY = GRAD_LAT + CORDIC_LAT + BAND_LAT;

  localparam logic [1:0] PROP_ALT   = 2'd0;
  localparam logic [1:0] PROP_SLOPE = 2'd1;

  typedef enum logic [2:0] {
    REG_MASK_MODE,
    REG_BAND_LOW,
    REG_BAND_HIGH,
    REG_FALLOFF_BELOW,
    REG_FALLOFF_ABOVE,
    REG_HALF_INV_X,
    REG_HALF_INV_Z,
    REG_STRENGTH
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]      mask_mode;
    logic [BW-1:0]   band_low;
    logic [BW-1:0]   band_high;
    logic [FW-1:0]   falloff_below;
    logic [FW-1:0]   falloff_above;
    logic [SPW-1:0]  half_inv_x;
    logic [SPW-1:0]  half_inv_z;
    logic [WW-1:0]   strength;
  } cfg_t;

  typedef struct packed {
    logic [HEIGHT_WIDTH-1:0] centre;
    logic [HEIGHT_WIDTH-1:0] west;
    logic [HEIGHT_WIDTH-1:0] east;
    logic [HEIGHT_WIDTH-1:0] north;
    logic [HEIGHT_WIDTH-1:0] south;
    logic                    centre_missing;
    logic                    west_missing;
    logic                    east_missing;
    logic                    north_missing;
    logic                    south_missing;
  } item_t;

  typedef struct packed {
    logic          zero;
    logic          use_slope;
    logic [XW-1:0] x;
  } side_t;

  // atan(2^-i) in degrees, Q.16
  function automatic logic [ZW-1:0] atan_q16(input int unsigned i);
    logic [ZW-1:0] v;
    case (i)
      0:       v = ZW'(2949120);
      1:       v = ZW'(1740967);
      2:       v = ZW'(919879);
      3:       v = ZW'(466945);
      4:       v = ZW'(234379);
      5:       v = ZW'(117304);
      6:       v = ZW'(58666);
      7:       v = ZW'(29335);
      8:       v = ZW'(14668);
      9:       v = ZW'(7334);
      10:      v = ZW'(3667);
      11:      v = ZW'(1833);
      12:      v = ZW'(917);
      13:      v = ZW'(458);
      14:      v = ZW'(229);
      15:      v = ZW'(115);
      16:      v = ZW'(57);
      17:      v = ZW'(29);
      18:      v = ZW'(14);
      19:      v = ZW'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/tbm_regs.sv =====
// Configuration register file of the band mask block, APB-style write and read.
// Depends on tbm_pkg.
module tbm_regs import tbm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask_mode     <= '0;
      cfg_q.band_low      <= '0;
      cfg_q.band_high     <= '0;
      cfg_q.falloff_below <= '0;
      cfg_q.falloff_above <= '0;
      cfg_q.half_inv_x    <= SPW'(65536);
      cfg_q.half_inv_z    <= SPW'(65536);
      cfg_q.strength      <= ONE_Q15;
    end else if (wr_en) begin
      unique case (idx)
        REG_MASK_MODE:     cfg_q.mask_mode     <= pwdata[2:0];
        REG_BAND_LOW:      cfg_q.band_low      <= pwdata[BW-1:0];
        REG_BAND_HIGH:     cfg_q.band_high     <= pwdata[BW-1:0];
        REG_FALLOFF_BELOW: cfg_q.falloff_below <= pwdata[FW-1:0];
        REG_FALLOFF_ABOVE: cfg_q.falloff_above <= pwdata[FW-1:0];
        REG_HALF_INV_X:    cfg_q.half_inv_x    <= pwdata[SPW-1:0];
        REG_HALF_INV_Z:    cfg_q.half_inv_z    <= pwdata[SPW-1:0];
        REG_STRENGTH:      cfg_q.strength      <= pwdata[WW-1:0];
        default:           cfg_q.mask_mode     <= cfg_q.mask_mode;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MASK_MODE:     prdata = 32'(cfg_q.mask_mode);
      REG_BAND_LOW:      prdata = 32'(cfg_q.band_low);
      REG_BAND_HIGH:     prdata = 32'(cfg_q.band_high);
      REG_FALLOFF_BELOW: prdata = 32'(cfg_q.falloff_below);
      REG_FALLOFF_ABOVE: prdata = 32'(cfg_q.falloff_above);
      REG_HALF_INV_X:    prdata = 32'(cfg_q.half_inv_x);
      REG_HALF_INV_Z:    prdata = 32'(cfg_q.half_inv_z);
      REG_STRENGTH:      prdata = 32'(cfg_q.strength);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/tbm_grad.sv =====
// Front pipeline: differences, curvature, gradient components, squared sum and
// a one-bit-per-stage integer square root. Depends on tbm_pkg.
module tbm_grad import tbm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  item_t            item_i,
  input  cfg_t             cfg_i,
  output logic             valid_o,
  output logic [ROOTW-1:0] g_o,
  output side_t            side_o
);

  localparam int HW = HEIGHT_WIDTH;

  // stage 1 logic
  logic signed [HW:0]   ex, ez;
  logic signed [HW+2:0] csum, cadj;
  logic [HW-1:0]        hw_s, he_s, hn_s, hs_s;
  logic [1:0]           prop;
  logic                 any_nb;
  side_t                side_d;
  logic [DW-1:0]        adx_d, adz_d;

  always_comb begin
    prop   = cfg_i.mask_mode[2:1];
    any_nb = item_i.west_missing || item_i.east_missing ||
             item_i.north_missing || item_i.south_missing;
    ex = $signed({item_i.east[HW-1], item_i.east}) - $signed({item_i.west[HW-1], item_i.west});
    ez = $signed({item_i.south[HW-1], item_i.south}) -
         $signed({item_i.north[HW-1], item_i.north});
    adx_d = ex[HW] ? DW'(-ex) : DW'(ex);
    adz_d = ez[HW] ? DW'(-ez) : DW'(ez);
    hw_s = item_i.west_missing  ? item_i.centre : item_i.west;
    he_s = item_i.east_missing  ? item_i.centre : item_i.east;
    hn_s = item_i.north_missing ? item_i.centre : item_i.north;
    hs_s = item_i.south_missing ? item_i.centre : item_i.south;
    csum = $signed({{3{hw_s[HW-1]}}, hw_s}) + $signed({{3{he_s[HW-1]}}, he_s}) +
           $signed({{3{hn_s[HW-1]}}, hn_s}) + $signed({{3{hs_s[HW-1]}}, hs_s}) -
           $signed({item_i.centre[HW-1], item_i.centre, 2'b00});
    cadj = csum + (HW+3)'(2);
    side_d.use_slope = (prop == PROP_SLOPE);
    side_d.zero      = item_i.centre_missing || ((prop == PROP_SLOPE) && any_nb);
    if (prop == PROP_ALT) begin
      side_d.x = {{(XW-HW){item_i.centre[HW-1]}}, item_i.centre};
    end else begin
      side_d.x = {{(XW-HW-1){cadj[HW+2]}}, cadj[HW+2:2]};
    end
  end

  logic             s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  side_t            s1_s_q, s2_s_q, s3_s_q, s4_s_q, s5_s_q;
  logic [DW-1:0]    s1_dx_q, s1_dz_q;
  logic [PW-1:0]    s2_px_q, s2_pz_q;
  logic [GW-1:0]    s3_a_q, s3_b_q;
  logic [2*GW-1:0]  s4_a2_q, s4_b2_q;
  logic [NW-1:0]    s5_n_q;

  logic [PW:0]      rx, rz;
  logic [GW-1:0]    a_d, b_d;

  always_comb begin
    rx  = {1'b0, s2_px_q} + (PW+1)'(128);
    rz  = {1'b0, s2_pz_q} + (PW+1)'(128);
    a_d = (rx[PW:8] > (PW-7)'(32'h7FFF_FFFF)) ? {GW{1'b1}} : rx[GW+7:8];
    b_d = (rz[PW:8] > (PW-7)'(32'h7FFF_FFFF)) ? {GW{1'b1}} : rz[GW+7:8];
  end

  // square root stages
  logic [RW-1:0] sq_n_q [SQRT_STEPS];
  logic [RW-1:0] sq_r_q [SQRT_STEPS];
  logic          sq_v_q [SQRT_STEPS];
  side_t         sq_s_q [SQRT_STEPS];
  logic [RW-1:0] sq_n_d [SQRT_STEPS];
  logic [RW-1:0] sq_r_d [SQRT_STEPS];

  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      logic [RW-1:0] in_n, in_r, bitv;
      logic [RW:0]   trial;
      in_n  = (k == 0) ? RW'(s5_n_q) : sq_n_q[(k == 0) ? 0 : k-1];
      in_r  = (k == 0) ? '0 : sq_r_q[(k == 0) ? 0 : k-1];
      bitv  = RW'(1) << (2 * (SQRT_STEPS - 1 - k));
      trial = {1'b0, in_r} + {1'b0, bitv};
      if ({1'b0, in_n} >= trial) begin
        sq_n_d[k] = in_n - trial[RW-1:0];
        sq_r_d[k] = (in_r >> 1) + bitv;
      end else begin
        sq_n_d[k] = in_n;
        sq_r_d[k] = in_r >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      for (int k = 0; k < SQRT_STEPS; k++) sq_v_q[k] <= 1'b0;
    end else begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      sq_v_q[0] <= s5_v_q;
      for (int k = 1; k < SQRT_STEPS; k++) sq_v_q[k] <= sq_v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_s_q  <= side_d;
    s1_dx_q <= adx_d;
    s1_dz_q <= adz_d;
    s2_s_q  <= s1_s_q;
    s2_px_q <= PW'(s1_dx_q) * PW'(cfg_i.half_inv_x);
    s2_pz_q <= PW'(s1_dz_q) * PW'(cfg_i.half_inv_z);
    s3_s_q  <= s2_s_q;
    s3_a_q  <= a_d;
    s3_b_q  <= b_d;
    s4_s_q  <= s3_s_q;
    s4_a2_q <= (2*GW)'(s3_a_q) * (2*GW)'(s3_a_q);
    s4_b2_q <= (2*GW)'(s3_b_q) * (2*GW)'(s3_b_q);
    s5_s_q  <= s4_s_q;
    s5_n_q  <= NW'(s4_a2_q) + NW'(s4_b2_q);
    sq_s_q[0] <= s5_s_q;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      sq_n_q[k] <= sq_n_d[k];
      sq_r_q[k] <= sq_r_d[k];
    end
    for (int k = 1; k < SQRT_STEPS; k++) sq_s_q[k] <= sq_s_q[k-1];
  end

  assign valid_o = sq_v_q[SQRT_STEPS-1];
  assign g_o     = sq_r_q[SQRT_STEPS-1][ROOTW-1:0];
  assign side_o  = sq_s_q[SQRT_STEPS-1];

endmodule

// ===== hw/rtl/tbm_cordic.sv =====
// Vectoring CORDIC, one rotation per stage, turning the gradient magnitude into
// a slope angle in Q.8 degrees and selecting the property. Depends on tbm_pkg.
module tbm_cordic import tbm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [ROOTW-1:0] g_i,
  input  side_t            side_i,
  output logic             valid_o,
  output side_t            side_o
);

  logic signed [CW-1:0] cx_q [CORDIC_STEPS];
  logic signed [CW-1:0] cy_q [CORDIC_STEPS];
  logic signed [ZW-1:0] cz_q [CORDIC_STEPS];
  logic                 cv_q [CORDIC_STEPS];
  logic                 cg_q [CORDIC_STEPS];
  side_t                cs_q [CORDIC_STEPS];
  logic signed [CW-1:0] cx_d [CORDIC_STEPS];
  logic signed [CW-1:0] cy_d [CORDIC_STEPS];
  logic signed [ZW-1:0] cz_d [CORDIC_STEPS];

  always_comb begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      logic signed [CW-1:0] ix, iy, dx, dy;
      logic signed [ZW-1:0] iz, at;
      ix = (i == 0) ? (CW'(1) <<< 32) : cx_q[(i == 0) ? 0 : i-1];
      iy = (i == 0) ? $signed(CW'(g_i) << 16) : cy_q[(i == 0) ? 0 : i-1];
      iz = (i == 0) ? '0 : cz_q[(i == 0) ? 0 : i-1];
      at = $signed(atan_q16(i));
      dx = iy >>> i;
      dy = ix >>> i;
      if (iy > 0) begin
        cx_d[i] = ix + dx;
        cy_d[i] = iy - dy;
        cz_d[i] = iz + at;
      end else begin
        cx_d[i] = ix - dx;
        cy_d[i] = iy + dy;
        cz_d[i] = iz - at;
      end
    end
  end

  // clamp to 0..90 degrees and round to Q.8
  logic signed [ZW-1:0] zl, zc;
  logic [SLW-1:0]       slope;
  side_t                out_d;

  always_comb begin
    zl = cz_q[CORDIC_STEPS-1];
    if (zl < 0) begin
      zc = '0;
    end else if (zl > ZW'(90 * 65536)) begin
      zc = ZW'(90 * 65536);
    end else begin
      zc = zl;
    end
    slope = SLW'((zc + ZW'(128)) >>> 8);
    out_d = cs_q[CORDIC_STEPS-1];
    if (out_d.use_slope) begin
      out_d.x = cg_q[CORDIC_STEPS-1] ? '0 : XW'(slope);
    end
  end

  logic  vo_q;
  side_t so_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CORDIC_STEPS; i++) cv_q[i] <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      cv_q[0] <= valid_i;
      for (int i = 1; i < CORDIC_STEPS; i++) cv_q[i] <= cv_q[i-1];
      vo_q <= cv_q[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    cs_q[0] <= side_i;
    cg_q[0] <= (g_i == '0);
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      cs_q[i] <= cs_q[i-1];
      cg_q[i] <= cg_q[i-1];
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      cx_q[i] <= cx_d[i];
      cy_q[i] <= cy_d[i];
      cz_q[i] <= cz_d[i];
    end
    so_q <= out_d;
  end

  assign valid_o = vo_q;
  assign side_o  = so_q;

endmodule

// ===== hw/rtl/tbm_band.sv =====
// Band weighting: edge compares, two restoring dividers for the smoothstep
// ramps, the smoothstep polynomial, inversion and strength blend. Depends on tbm_pkg.
module tbm_band import tbm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  side_t         side_i,
  input  cfg_t          cfg_i,
  output logic          valid_o,
  output logic [WW-1:0] weight_o
);

  localparam logic [1:0] SEL_ZERO = 2'd0;
  localparam logic [1:0] SEL_ONE  = 2'd1;
  localparam logic [1:0] SEL_RAMP = 2'd2;

  logic signed [XW-1:0] x, lo, hi, from_lo, to_hi, dr, df;
  logic [1:0]           rsel_d, fsel_d;

  always_comb begin
    x       = $signed(side_i.x);
    lo      = $signed({{(XW-BW){cfg_i.band_low[BW-1]}}, cfg_i.band_low});
    hi      = $signed({{(XW-BW){cfg_i.band_high[BW-1]}}, cfg_i.band_high});
    from_lo = lo - $signed({{(XW-FW){1'b0}}, cfg_i.falloff_below});
    to_hi   = hi + $signed({{(XW-FW){1'b0}}, cfg_i.falloff_above});
    dr      = x - from_lo;
    df      = x - hi;
    if (x >= lo) begin
      rsel_d = SEL_ONE;
    end else if ((cfg_i.falloff_below != '0) && (x > from_lo)) begin
      rsel_d = SEL_RAMP;
    end else begin
      rsel_d = SEL_ZERO;
    end
    if (x <= hi) begin
      fsel_d = SEL_ONE;
    end else if ((cfg_i.falloff_above != '0) && (x < to_hi)) begin
      fsel_d = SEL_RAMP;
    end else begin
      fsel_d = SEL_ZERO;
    end
  end

  logic          b1_v_q, b1_z_q;
  logic [1:0]    b1_rs_q, b1_fs_q;
  logic [FW-1:0] b1_rr_q, b1_fr_q;

  // divider stages
  logic                 dv_v_q  [DIV_STEPS];
  logic                 dv_z_q  [DIV_STEPS];
  logic [1:0]           dv_rs_q [DIV_STEPS];
  logic [1:0]           dv_fs_q [DIV_STEPS];
  logic [FW-1:0]        dv_rr_q [DIV_STEPS];
  logic [FW-1:0]        dv_fr_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_rq_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_fq_q [DIV_STEPS];
  logic [FW-1:0]        dv_rr_d [DIV_STEPS];
  logic [FW-1:0]        dv_fr_d [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_rq_d [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_fq_d [DIV_STEPS];

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      logic [FW-1:0]        ir, jf;
      logic [DIV_STEPS-1:0] iq, jq;
      logic [FW:0]          r2, f2;
      logic                 rg, fg;
      ir = (k == 0) ? b1_rr_q : dv_rr_q[(k == 0) ? 0 : k-1];
      jf = (k == 0) ? b1_fr_q : dv_fr_q[(k == 0) ? 0 : k-1];
      iq = (k == 0) ? '0 : dv_rq_q[(k == 0) ? 0 : k-1];
      jq = (k == 0) ? '0 : dv_fq_q[(k == 0) ? 0 : k-1];
      r2 = {ir, 1'b0};
      f2 = {jf, 1'b0};
      rg = (r2 >= {1'b0, cfg_i.falloff_below});
      fg = (f2 >= {1'b0, cfg_i.falloff_above});
      dv_rr_d[k] = rg ? FW'(r2 - {1'b0, cfg_i.falloff_below}) : r2[FW-1:0];
      dv_fr_d[k] = fg ? FW'(f2 - {1'b0, cfg_i.falloff_above}) : f2[FW-1:0];
      dv_rq_d[k] = {iq[DIV_STEPS-2:0], rg};
      dv_fq_d[k] = {jq[DIV_STEPS-2:0], fg};
    end
  end

  // polynomial and blend stages
  logic                 p1_v_q, p2_v_q, p3_v_q, out_v_q;
  logic                 p1_z_q, p2_z_q, p3_z_q;
  logic [1:0]           p1_rs_q, p1_fs_q, p2_rs_q, p2_fs_q;
  logic [2*DIV_STEPS-1:0] p1_rt2_q, p1_ft2_q;
  logic [16:0]          p1_rc_q, p1_fc_q;
  logic [46:0]          p2_rp_q, p2_fp_q;
  logic [2*WW-1:0]      p3_m_q;
  logic [WW-1:0]        out_w_q;

  logic [DIV_STEPS-1:0] rt, ft;
  logic [47:0]          rpr, fpr;
  logic [WW-1:0]        rs_v, fs_v, rise_v, fall_v, w, wi, str;
  logic [2*WW:0]        mr;

  always_comb begin
    rt     = dv_rq_q[DIV_STEPS-1];
    ft     = dv_fq_q[DIV_STEPS-1];
    rpr    = {1'b0, p2_rp_q} + 48'(1 << 29);
    fpr    = {1'b0, p2_fp_q} + 48'(1 << 29);
    rs_v   = rpr[45:30];
    fs_v   = fpr[45:30];
    case (p2_rs_q)
      SEL_ONE:  rise_v = ONE_Q15;
      SEL_RAMP: rise_v = rs_v;
      default:  rise_v = '0;
    endcase
    case (p2_fs_q)
      SEL_ONE:  fall_v = ONE_Q15;
      SEL_RAMP: fall_v = ONE_Q15 - fs_v;
      default:  fall_v = '0;
    endcase
    w   = (rise_v < fall_v) ? rise_v : fall_v;
    wi  = cfg_i.mask_mode[0] ? (ONE_Q15 - w) : w;
    str = (cfg_i.strength > ONE_Q15) ? ONE_Q15 : cfg_i.strength;
    mr  = {1'b0, p3_m_q} + (2*WW+1)'(16384);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      for (int k = 0; k < DIV_STEPS; k++) dv_v_q[k] <= 1'b0;
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      b1_v_q    <= valid_i;
      dv_v_q[0] <= b1_v_q;
      for (int k = 1; k < DIV_STEPS; k++) dv_v_q[k] <= dv_v_q[k-1];
      p1_v_q  <= dv_v_q[DIV_STEPS-1];
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      out_v_q <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_z_q  <= side_i.zero;
    b1_rs_q <= rsel_d;
    b1_fs_q <= fsel_d;
    b1_rr_q <= dr[FW-1:0];
    b1_fr_q <= df[FW-1:0];
    dv_z_q[0]  <= b1_z_q;
    dv_rs_q[0] <= b1_rs_q;
    dv_fs_q[0] <= b1_fs_q;
    for (int k = 1; k < DIV_STEPS; k++) begin
      dv_z_q[k]  <= dv_z_q[k-1];
      dv_rs_q[k] <= dv_rs_q[k-1];
      dv_fs_q[k] <= dv_fs_q[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv_rr_q[k] <= dv_rr_d[k];
      dv_fr_q[k] <= dv_fr_d[k];
      dv_rq_q[k] <= dv_rq_d[k];
      dv_fq_q[k] <= dv_fq_d[k];
    end
    p1_z_q   <= dv_z_q[DIV_STEPS-1];
    p1_rs_q  <= dv_rs_q[DIV_STEPS-1];
    p1_fs_q  <= dv_fs_q[DIV_STEPS-1];
    p1_rt2_q <= (2*DIV_STEPS)'(rt) * (2*DIV_STEPS)'(rt);
    p1_ft2_q <= (2*DIV_STEPS)'(ft) * (2*DIV_STEPS)'(ft);
    p1_rc_q  <= 17'd98304 - {1'b0, rt, 1'b0};
    p1_fc_q  <= 17'd98304 - {1'b0, ft, 1'b0};
    p2_z_q   <= p1_z_q;
    p2_rs_q  <= p1_rs_q;
    p2_fs_q  <= p1_fs_q;
    p2_rp_q  <= 47'(p1_rt2_q) * 47'(p1_rc_q);
    p2_fp_q  <= 47'(p1_ft2_q) * 47'(p1_fc_q);
    p3_z_q   <= p2_z_q;
    p3_m_q   <= (2*WW)'(ONE_Q15 - wi) * (2*WW)'(str);
    out_w_q  <= p3_z_q ? '0 : (ONE_Q15 - mr[WW+14:15]);
  end

  assign valid_o  = out_v_q;
  assign weight_o = out_w_q;

endmodule

// ===== hw/rtl/terrain_band_mask_core.sv =====
// Top level of the terrain band mask block: register file and the three
// pipeline sections. Depends on tbm_pkg, tbm_regs, tbm_grad, tbm_cordic, tbm_band.
//
// Usage:
//   Drive one cell per transaction: centre height and its four cross
//   neighbours (Q15.8, border-clamped) with their missing flags, and raise
//   start. The transaction is taken at every clock edge with start high and
//   busy low; busy never rises, so one cell can enter every cycle.
//   Each cell yields one mask_weight (Q1.15), shown for one cycle with done
//   high, after its start edge, in order.
//   The pipeline holds 5 gradient stages, 32 square root stages (one root
//   bit each), 20 CORDIC rotations plus a clamp stage, and the band section
//   with a 15-stage restoring divider and 5 more stages.
//   The receiver cannot stall; results are never held.
//   Configuration goes through the APB-style port (register i at 4*i); the
//   user must write it only while no transaction is in flight; the block
//   does not enforce this. pready is always high. Reset clears all valid
//   bits and loads the register reset values; no clearing pass is needed.
module terrain_band_mask_core import tbm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    start,
  output logic                    busy,
  input  logic [HEIGHT_WIDTH-1:0] centre_height_i,
  input  logic                    centre_missing_i,
  input  logic [HEIGHT_WIDTH-1:0] west_height_i,
  input  logic                    west_missing_i,
  input  logic [HEIGHT_WIDTH-1:0] east_height_i,
  input  logic                    east_missing_i,
  input  logic [HEIGHT_WIDTH-1:0] north_height_i,
  input  logic                    north_missing_i,
  input  logic [HEIGHT_WIDTH-1:0] south_height_i,
  input  logic                    south_missing_i,
  output logic                    done_o,
  output logic [WW-1:0]           mask_weight_o
);

  cfg_t             cfg;
  item_t            item;
  logic             grad_v, cor_v;
  logic [ROOTW-1:0] grad_g;
  side_t            grad_s, cor_s;

  // The pipeline never stalls, so never hold off a transaction.
  assign busy = 1'b0;

  always_comb begin
    item.centre         = centre_height_i;
    item.west           = west_height_i;
    item.east           = east_height_i;
    item.north          = north_height_i;
    item.south          = south_height_i;
    item.centre_missing = centre_missing_i;
    item.west_missing   = west_missing_i;
    item.east_missing   = east_missing_i;
    item.north_missing  = north_missing_i;
    item.south_missing  = south_missing_i;
  end

  tbm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Gradient magnitude; altitude and curvature ride along as side data.
  tbm_grad u_grad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .item_i  (item),
    .cfg_i   (cfg),
    .valid_o (grad_v),
    .g_o     (grad_g),
    .side_o  (grad_s)
  );

  // Slope angle and property select.
  tbm_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (grad_v),
    .g_i     (grad_g),
    .side_i  (grad_s),
    .valid_o (cor_v),
    .side_o  (cor_s)
  );

  // Band weight, inversion and strength blend; drives the result strobe.
  tbm_band u_band (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (cor_v),
    .side_i   (cor_s),
    .cfg_i    (cfg),
    .valid_o  (done_o),
    .weight_o (mask_weight_o)
  );

endmodule

// ===== hw/rtl/tbm_checker.sv =====
// Port-level checker for the terrain band mask block, bound to the top level.
// Depends on tbm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tbm_checker import tbm_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          centre_missing_i,
  input logic          done_o,
  input logic [WW-1:0] mask_weight_o
);

  `TBM_ASSERT(a_done_follows, (start && !busy) |-> ##TBM_LATENCY done_o)
  `TBM_ASSERT(a_done_caused, done_o |-> $past(start && !busy, TBM_LATENCY))
  `TBM_ASSERT(a_missing_zero, (start && !busy && centre_missing_i) |-> ##TBM_LATENCY (mask_weight_o == '0))
  `TBM_ASSERT_NEVER(a_weight_range, done_o && (mask_weight_o > ONE_Q15))

endmodule

bind terrain_band_mask_core tbm_checker u_tbm_checker (.*);

// ===== tb/tbm_weight_checker.sv =====
`timescale 1ns / 100ps
// Checker for terrain_band_mask_core: follows register writes, predicts each mask weight
// and compares the results in order. Depends on tbm_pkg.
module tbm_weight_checker import tbm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel_i,
  input  logic                    penable_i,
  input  logic                    pwrite_i,
  input  logic                    pready_i,
  input  logic [ADDR_W-1:0]       paddr_i,
  input  logic [31:0]             pwdata_i,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  item_t                   cell_i,
  input  logic                    done_i,
  input  logic [WW-1:0]           mask_weight_i,
  output int                      fail_count_o,
  output int                      outstanding_o,
  output int                      cells_o,
  output int                      weights_o
);

  localparam longint ONE = 32768;

  // atan(2^-i) in degrees, Q.16
  localparam longint ATAN_DEG [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

  cfg_t          cfg;
  logic [WW-1:0] weight_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, pw;
    r  = 0;
    pw = 64'd1 << 62;
    while (pw > n) pw >>= 2;
    while (pw != 0) begin
      if (n >= r + pw) begin
        n -= r + pw;
        r = (r >> 1) + pw;
      end else begin
        r >>= 1;
      end
      pw >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned grad_component(longint hi_side, longint lo_side,
                                                     longint unsigned inv);
    longint          d;
    longint unsigned p;
    d = hi_side - lo_side;
    p = ((d < 0 ? -d : d) * inv + 128) >> 8;
    return (p > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : p;
  endfunction

  // Slope angle in Q.8 degrees by CORDIC vectoring on (1, g).
  function automatic longint slope_degrees(longint unsigned a, longint unsigned b);
    longint unsigned g;
    longint          xv, yv, z, dx, dy;
    g = int_sqrt(a * a + b * b);
    if (g == 0) return 0;
    xv = 64'sd1 << 32;
    yv = longint'(g << 16);
    z  = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv > 0) begin
        xv += dx; yv -= dy; z += ATAN_DEG[i];
      end else begin
        xv -= dx; yv += dy; z -= ATAN_DEG[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * 65536) z = 90 * 65536;
    return (z + 128) >>> 8;
  endfunction

  function automatic longint smooth_edge(longint from, longint to, longint xv);
    longint t;
    if (xv <= from) return 0;
    if (xv >= to) return ONE;
    t = ((xv - from) << 15) / (to - from);
    return (t * t * (98304 - 2 * t) + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic logic [WW-1:0] predict_weight(item_t c, cfg_t r);
    longint ch, hw, he, hn, hs, xv, lo, hi, flo, fhi, s, rise, fall, w;
    logic [1:0] prop;
    ch   = longint'(signed'(c.centre));
    hw   = longint'(signed'(c.west));
    he   = longint'(signed'(c.east));
    hn   = longint'(signed'(c.north));
    hs   = longint'(signed'(c.south));
    prop = r.mask_mode[2:1];
    lo   = longint'(signed'(r.band_low));
    hi   = longint'(signed'(r.band_high));
    flo  = longint'(r.falloff_below);
    fhi  = longint'(r.falloff_above);
    s    = (r.strength > ONE_Q15) ? ONE : longint'(r.strength);
    if (c.centre_missing) return '0;
    if (prop == PROP_ALT) begin
      xv = ch;
    end else if (prop == PROP_SLOPE) begin
      if (c.west_missing || c.east_missing || c.north_missing || c.south_missing)
        return '0;
      xv = slope_degrees(grad_component(he, hw, r.half_inv_x),
                         grad_component(hs, hn, r.half_inv_z));
    end else begin
      // curvature: absent neighbours take the centre height
      xv = (c.west_missing  ? ch : hw) + (c.east_missing  ? ch : he) +
           (c.north_missing ? ch : hn) + (c.south_missing ? ch : hs) - 4 * ch;
      xv = (xv + 2) >>> 2;
    end
    rise = (xv >= lo) ? ONE : (flo > 0 ? smooth_edge(lo - flo, lo, xv) : 0);
    fall = (xv <= hi) ? ONE : (fhi > 0 ? ONE - smooth_edge(hi, hi + fhi, xv) : 0);
    w = (rise < fall) ? rise : fall;
    if (r.mask_mode[0]) w = ONE - w;
    return WW'(ONE - (((ONE - w) * s + 16384) >>> 15));
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t MISMATCH %s", $realtime, what);
    fail_count_o++;
  endtask

  assign outstanding_o = weight_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg          <= '{mask_mode: '0, band_low: '0, band_high: '0, falloff_below: '0,
                        falloff_above: '0, half_inv_x: 24'd65536, half_inv_z: 24'd65536,
                        strength: ONE_Q15};
      fail_count_o = 0;
      cells_o      <= 0;
      weights_o    <= 0;
      weight_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[ADDR_W-1:2]))
          REG_MASK_MODE:     cfg.mask_mode     <= pwdata_i[2:0];
          REG_BAND_LOW:      cfg.band_low      <= pwdata_i[BW-1:0];
          REG_BAND_HIGH:     cfg.band_high     <= pwdata_i[BW-1:0];
          REG_FALLOFF_BELOW: cfg.falloff_below <= pwdata_i[FW-1:0];
          REG_FALLOFF_ABOVE: cfg.falloff_above <= pwdata_i[FW-1:0];
          REG_HALF_INV_X:    cfg.half_inv_x    <= pwdata_i[SPW-1:0];
          REG_HALF_INV_Z:    cfg.half_inv_z    <= pwdata_i[SPW-1:0];
          REG_STRENGTH:      cfg.strength      <= pwdata_i[WW-1:0];
          default: ;
        endcase
      end
      if (done_i) begin
        weights_o <= weights_o + 1;
        if (weight_q.size() == 0)
          report_mismatch($sformatf("weight %0d with nothing pending", mask_weight_i));
        else if (weight_q[0] !== mask_weight_i)
          report_mismatch($sformatf("mask_weight got %0d want %0d", mask_weight_i,
                                    weight_q[0]));
        if (weight_q.size() != 0) void'(weight_q.pop_front());
      end
      if (start_i && !busy_i) begin
        weight_q.push_back(predict_weight(cell_i, cfg));
        cells_o <= cells_o + 1;
      end
    end
  end

endmodule

// ===== tb/tb_terrain_band_mask_core.sv =====
`timescale 1ns / 100ps
// Testbench top for terrain_band_mask_core: drives cells and register writes, gives the verdict.
// Depends on tbm_pkg, terrain_band_mask_core and tbm_weight_checker.
module tb_terrain_band_mask_core;
  import tbm_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              start   = 1'b0;
  logic              busy;
  item_t             stim    = '0;
  logic              done_o;
  logic [WW-1:0]     mask_weight_o;

  int fail_count, outstanding, cells, weights;
  int quiet_cycles = 0;

  terrain_band_mask_core DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy,
    .centre_height_i(stim.centre), .centre_missing_i(stim.centre_missing),
    .west_height_i  (stim.west),   .west_missing_i  (stim.west_missing),
    .east_height_i  (stim.east),   .east_missing_i  (stim.east_missing),
    .north_height_i (stim.north),  .north_missing_i (stim.north_missing),
    .south_height_i (stim.south),  .south_missing_i (stim.south_missing),
    .done_o, .mask_weight_o
  );

  tbm_weight_checker checker_i (
    .clk_i, .rst_ni, .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite),
    .pready_i(pready), .paddr_i(paddr), .pwdata_i(pwdata), .start_i(start),
    .busy_i(busy), .cell_i(stim), .done_i(done_o), .mask_weight_i(mask_weight_o),
    .fail_count_o(fail_count), .outstanding_o(outstanding), .cells_o(cells),
    .weights_o(weights)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: count cycles in which no transaction, result or register write completes.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles", quiet_cycles);
      $display("terrain_band_mask_core verification failed");
      $finish;
    end
  end

  // Write one register: setup cycle, then access cycle.
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain the pipeline, then load a full register set.
  task automatic load_band(logic [2:0] mode, int lo, int hi, int flo, int fhi,
                           int hx, int hz, int str);
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (TBM_LATENCY + 4) @(posedge clk_i);
    write_reg(REG_MASK_MODE, 32'(mode));
    write_reg(REG_BAND_LOW, 32'(lo));
    write_reg(REG_BAND_HIGH, 32'(hi));
    write_reg(REG_FALLOFF_BELOW, 32'(flo));
    write_reg(REG_FALLOFF_ABOVE, 32'(fhi));
    write_reg(REG_HALF_INV_X, 32'(hx));
    write_reg(REG_HALF_INV_Z, 32'(hz));
    write_reg(REG_STRENGTH, 32'(str));
  endtask

  // Present one cell and hold it until taken; if allowed, sometimes drop start for a random gap.
  task automatic send_cell(item_t c, bit may_idle);
    stim  <= c;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (may_idle && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  function automatic item_t make_cell(logic [23:0] c, logic [23:0] w, logic [23:0] e,
                                      logic [23:0] n, logic [23:0] s, logic [4:0] miss);
    item_t it;
    it = '{centre: c, west: w, east: e, north: n, south: s, centre_missing: miss[4],
           west_missing: miss[3], east_missing: miss[2], north_missing: miss[1],
           south_missing: miss[0]};
    return it;
  endfunction

  // Mostly smooth terrain around a base height, sometimes fully random bits.
  function automatic item_t random_cell();
    item_t it;
    int    base, span;
    it = '0;
    if ($urandom_range(0, 3) == 0) begin
      it.centre = 24'($urandom); it.west = 24'($urandom); it.east = 24'($urandom);
      it.north  = 24'($urandom); it.south = 24'($urandom);
    end else begin
      base = $urandom_range(0, 32'hFFFFFF) - 32'h800000;
      span = 1 << $urandom_range(0, 16);
      it.centre = 24'(base);
      it.west   = 24'(base + $urandom_range(0, 2 * span) - span);
      it.east   = 24'(base + $urandom_range(0, 2 * span) - span);
      it.north  = 24'(base + $urandom_range(0, 2 * span) - span);
      it.south  = 24'(base + $urandom_range(0, 2 * span) - span);
    end
    it.centre_missing = ($urandom_range(0, 99) < 5);
    it.west_missing   = ($urandom_range(0, 99) < 5);
    it.east_missing   = ($urandom_range(0, 99) < 5);
    it.north_missing  = ($urandom_range(0, 99) < 5);
    it.south_missing  = ($urandom_range(0, 99) < 5);
    return it;
  endfunction

  // Pick a register set scaled to the property the mode selects.
  task automatic random_band();
    logic [2:0] mode;
    int scale, lo, hi, flo, fhi, hx, hz, str;
    mode  = 3'($urandom_range(0, 7));
    scale = (mode[2:1] == PROP_ALT) ? 32'h400000 :
            (mode[2:1] == PROP_SLOPE) ? 23040 : 4096;
    lo  = $urandom_range(0, 2 * scale) - scale;
    if (mode[2:1] == PROP_SLOPE) lo = $urandom_range(0, scale);
    hi  = ($urandom_range(0, 9) == 0) ? lo - $urandom_range(1, scale)
                                      : lo + $urandom_range(0, scale);
    flo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, scale);
    fhi = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, scale);
    if ($urandom_range(0, 19) == 0) flo = 32'h7FFFFF;
    if ($urandom_range(0, 19) == 0) fhi = 32'h7FFFFF;
    hx  = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(0, 1 << 18);
    hz  = ($urandom_range(0, 19) == 0) ? 32'hFFFFFF : $urandom_range(0, 1 << 18);
    str = ($urandom_range(0, 2) == 0) ? 32768 : $urandom_range(0, 65535);
    load_band(mode, lo, hi, flo, fhi, hx, hz, str);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: altitude, zero-width band at 0.
    send_cell(make_cell(24'h7FFFFF, 0, 0, 0, 0, 5'b00000), 1'b0);
    send_cell(make_cell(24'h800000, 0, 0, 0, 0, 5'b00000), 1'b0);
    send_cell(make_cell(24'h000000, 0, 0, 0, 0, 5'b00000), 1'b0);
    send_cell(make_cell(24'h000000, 0, 0, 0, 0, 5'b10000), 1'b0);

    // Widest band and falloffs, inverted altitude, zero strength.
    load_band(3'b001, 32'hFF800000, 32'h7FFFFF, 32'h7FFFFF, 32'h7FFFFF, 65536, 65536, 0);
    send_cell(make_cell(24'h7FFFFF, 0, 0, 0, 0, 5'b00000), 1'b0);
    send_cell(make_cell(24'h800000, 0, 0, 0, 0, 5'b00000), 1'b0);

    // Slope: flat ground, saturated gradient, missing neighbour.
    load_band(3'b010, 5000, 12000, 2000, 3000, 32'hFFFFFF, 32'hFFFFFF, 32768);
    send_cell(make_cell(100, 100, 100, 100, 100, 5'b00000), 1'b0);
    send_cell(make_cell(0, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 5'b00000), 1'b0);
    send_cell(make_cell(0, 0, 256, 0, 512, 5'b00000), 1'b0);
    send_cell(make_cell(0, 0, 256, 0, 512, 5'b00100), 1'b0);
    send_cell(make_cell(0, 0, 256, 0, 512, 5'b00001), 1'b0);

    // Slope with a zero spacing register on x, strength above one.
    load_band(3'b011, 0, 4000, 0, 0, 0, 65536, 65535);
    send_cell(make_cell(0, 0, 9000, 0, 300, 5'b00000), 1'b0);
    send_cell(make_cell(0, 0, 9000, 0, 0, 5'b00000), 1'b0);

    // Curvature and selector three, with missing neighbours; crossed band.
    load_band(3'b100, -500, 500, 300, 300, 65536, 65536, 20000);
    send_cell(make_cell(0, 400, 400, 400, 400, 5'b00000), 1'b0);
    send_cell(make_cell(0, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 5'b00000), 1'b0);
    send_cell(make_cell(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                        5'b00000), 1'b0);
    send_cell(make_cell(1000, 0, 0, 0, 0, 5'b01111), 1'b0);
    load_band(3'b111, 800, -800, 100, 0, 65536, 65536, 32768);
    send_cell(make_cell(0, 800, 800, 800, 800, 5'b00000), 1'b0);
    send_cell(make_cell(0, -3000, 0, 0, 0, 5'b00010), 1'b0);
    send_cell(make_cell(0, 3200, 0, 0, 0, 5'b00000), 1'b0);

    // Random phases; one phase runs back to back without gaps.
    for (int ph = 0; ph < 12; ph++) begin
      random_band();
      for (int k = 0; k < 160; k++)
        send_cell(random_cell(), ph != 5);
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (TBM_LATENCY + 4) @(posedge clk_i);

    $display("covered %0d cells and %0d weights over altitude, slope and curvature bands",
             cells, weights);
    $display("with inversion, falloff, strength and missing-height cases");
    if (fail_count == 0)
      $display("terrain_band_mask_core verification clean");
    else
      $display("terrain_band_mask_core verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tbm_pkg.sv
hw/rtl/tbm_regs.sv
hw/rtl/tbm_grad.sv
hw/rtl/tbm_cordic.sv
hw/rtl/tbm_band.sv
hw/rtl/terrain_band_mask_core.sv
hw/rtl/tbm_checker.sv
tb/tbm_weight_checker.sv
tb/tb_terrain_band_mask_core.sv
